### sv/xmr_pkg.sv
// ----------------------------------------------------------------------------
// XMODEM receiver package
// Shared types, protocol byte codes and register indexes.
// ----------------------------------------------------------------------------
package xmr_pkg;

	localparam logic [7:0] B_SOH = 8'h01;
	localparam logic [7:0] B_STX = 8'h02;
	localparam logic [7:0] B_EOT = 8'h04;
	localparam logic [7:0] B_ACK = 8'h06;
	localparam logic [7:0] B_NAK = 8'h15;
	localparam logic [7:0] B_CAN = 8'h18;
	localparam logic [7:0] B_C   = 8'h43;

	localparam logic [4:0] RETRANS_RESET = 5'd25;

	typedef enum logic [1:0] {
		IK_START = 2'd0,
		IK_BYTE  = 2'd1,
		IK_TICK  = 2'd2,
		IK_NONE  = 2'd3
	} in_kind_t;

	typedef enum logic [1:0] {
		OK_TX     = 2'd0,
		OK_DATA   = 2'd1,
		OK_FINISH = 2'd2
	} out_kind_t;

	typedef enum logic [2:0] {
		REG_DEST_SIZE = 3'd0,
		REG_START_TO  = 3'd1,
		REG_BYTE_TO   = 3'd2,
		REG_FLUSH     = 3'd3,
		REG_MAX_RETR  = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_PROBE = 4'd1,
		PH_CANW  = 4'd2,
		PH_BLOCK = 4'd3,
		PH_FLUSH = 4'd4
	} phase_t;

	typedef enum logic [1:0] {
		PR_NONE = 2'd0,
		PR_C    = 2'd1,
		PR_NAK  = 2'd2
	} probe_t;

	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_NAK    = 3'd1,
		ACT_END    = 3'd2,
		ACT_CANCEL = 3'd3,
		ACT_SYNC   = 3'd4,
		ACT_RETRY  = 3'd5
	} act_t;

	typedef enum logic [1:0] {
		ST_NORMAL = 2'd0,
		ST_CANCEL = 2'd1,
		ST_SYNC   = 2'd2,
		ST_RETRY  = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [7:0]  out_byte;
		logic [23:0] offset;
		logic [23:0] total_length;
		logic [1:0]  status;
		logic        last;
	} result_t;

	// Up to four results from one input item, already ordered.
	typedef struct packed {
		logic [2:0]  count;
		result_t [3:0] res;
	} result_group_t;

	typedef struct packed {
		logic [23:0] dest_size;
		logic [15:0] start_to;
		logic [15:0] byte_to;
		logic [15:0] flush_to;
		logic [4:0]  max_retrans;
	} cfg_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) c = {c[14:0], 1'b0} ^ 16'h1021;
			else c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic result_t mk_res(input logic [1:0] k, input logic [7:0] b,
		input logic [23:0] off, input logic [23:0] tot, input logic [1:0] st);
		result_t r;
		r.out_kind = k;
		r.out_byte = b;
		r.offset = off;
		r.total_length = tot;
		r.status = st;
		r.last = 1'b0;
		return r;
	endfunction

endpackage

### sv/xmr_if.sv
// ----------------------------------------------------------------------------
// XMODEM receiver channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface xmr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] rx_byte;
	modport source(output valid, kind, rx_byte, input ready);
	modport sink(input valid, kind, rx_byte, output ready);
endinterface

interface xmr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_kind;
	logic [7:0]  out_byte;
	logic [23:0] offset;
	logic [23:0] total_length;
	logic [1:0]  status;
	logic        last;
	modport source(output valid, out_kind, out_byte, offset, total_length, status, last,
		input ready);
	modport sink(input valid, out_kind, out_byte, offset, total_length, status, last,
		output ready);
endinterface

### sv/xmodem_block_receiver_unit.sv
// ----------------------------------------------------------------------------
// XMODEM block receiver
// CRC/checksum XMODEM receiver with payload write and session results.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// in_ch     in   kind, rx_byte
// out_ch    out  out_kind, out_byte, offset, total_length, status, last
// cfg       in   cfg_we, cfg_index, cfg_data (write only)
//
// One input transaction is taken per cycle while the result queue has room
// for four entries; its results enter the queue at that same edge.
// Results leave one per cycle when taken; ready drops with over four queued.
// Reset puts the session idle and restores the register defaults.
module xmodem_block_receiver_unit
	import xmr_pkg::*;
#(
	parameter int TRIES_PER_ROUND = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	xmr_in_if.sink      in_ch,
	xmr_out_if.source   out_ch
);
	cfg_t          cfg;
	result_group_t grp;
	logic          room4, step;

	assign in_ch.ready = room4;
	assign step = in_ch.valid && room4;

	xmr_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cfg(cfg)
	);

	xmr_core #(.TRIES_PER_ROUND(TRIES_PER_ROUND)) u_core (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .step(step), .kind(in_ch.kind),
		.rx_byte(in_ch.rx_byte), .grp(grp)
	);

	xmr_outq u_outq (
		.clk(clk), .arst_n(arst_n), .push(step), .grp(grp), .room4(room4),
		.out_ch(out_ch)
	);
endmodule

### sv/xmr_cfg.sv
// ----------------------------------------------------------------------------
// XMODEM receiver configuration registers
// Holds the five settings; a timeout of zero is presented as one.
// ----------------------------------------------------------------------------
module xmr_cfg
	import xmr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output cfg_t        cfg
);
	logic [23:0] dest_q;
	logic [15:0] st_q, bt_q, fl_q;
	logic [4:0]  mr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_q <= 24'hFFFFFF;
			st_q <= 16'd2000;
			bt_q <= 16'd1000;
			fl_q <= 16'd1500;
			mr_q <= RETRANS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEST_SIZE: dest_q <= cfg_data;
				REG_START_TO:  st_q <= cfg_data[15:0];
				REG_BYTE_TO:   bt_q <= cfg_data[15:0];
				REG_FLUSH:     fl_q <= cfg_data[15:0];
				REG_MAX_RETR:  mr_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.dest_size = dest_q;
		cfg.start_to = (st_q == 16'd0) ? 16'd1 : st_q;
		cfg.byte_to = (bt_q == 16'd0) ? 16'd1 : bt_q;
		cfg.flush_to = (fl_q == 16'd0) ? 16'd1 : fl_q;
		cfg.max_retrans = mr_q;
	end
endmodule

### sv/xmr_core.sv
// ----------------------------------------------------------------------------
// XMODEM receiver protocol core
// Session state and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
module xmr_core
	import xmr_pkg::*;
#(
	parameter int TRIES_PER_ROUND = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          step,
	input  logic [1:0]    kind,
	input  logic [7:0]    rx_byte,
	output result_group_t grp
);
	localparam logic [4:0] TRIES = 5'(TRIES_PER_ROUND);

	phase_t      phase_q, phase_n;
	logic [4:0]  try_q, try_n;
	probe_t      probe_q, probe_n;
	logic        crcm_q, crcm_n;
	logic [7:0]  exp_q, exp_n;
	logic [4:0]  retr_q, retr_n;
	logic [23:0] clen_q, clen_n;
	logic [10:0] idx_q, idx_n;
	logic        long_q, long_n;
	logic [7:0]  bnum_q, bnum_n, bcmp_q, bcmp_n;
	logic [15:0] crc_q, crc_n;
	logic [7:0]  sum_q, sum_n, crch_q, crch_n;
	logic [15:0] tmr_q, tmr_n;
	act_t        act_q, act_n;

	result_group_t g;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; try_q <= '0; probe_q <= PR_C; crcm_q <= 1'b0;
			exp_q <= 8'd1; retr_q <= RETRANS_RESET; clen_q <= '0; idx_q <= '0;
			long_q <= 1'b0; bnum_q <= '0; bcmp_q <= '0; crc_q <= '0; sum_q <= '0;
			crch_q <= '0; tmr_q <= '0; act_q <= ACT_NONE;
		end else if (step) begin
			phase_q <= phase_n; try_q <= try_n; probe_q <= probe_n; crcm_q <= crcm_n;
			exp_q <= exp_n; retr_q <= retr_n; clen_q <= clen_n; idx_q <= idx_n;
			long_q <= long_n; bnum_q <= bnum_n; bcmp_q <= bcmp_n; crc_q <= crc_n;
			sum_q <= sum_n; crch_q <= crch_n; tmr_q <= tmr_n; act_q <= act_n;
		end
	end

	always_comb begin
		logic [15:0] tmr_inc;
		logic        do_next_try, do_probe, check_ok, blk_done, ok, is_new;
		logic [10:0] size;
		logic [4:0]  try_p1;
		logic [23:0] room, add;
		logic [24:0] off;
		logic [4:0]  retr_after;
		logic [7:0]  prev;

		phase_n = phase_q; try_n = try_q; probe_n = probe_q; crcm_n = crcm_q;
		exp_n = exp_q; retr_n = retr_q; clen_n = clen_q; idx_n = idx_q;
		long_n = long_q; bnum_n = bnum_q; bcmp_n = bcmp_q; crc_n = crc_q;
		sum_n = sum_q; crch_n = crch_q; tmr_n = tmr_q; act_n = act_q;
		g = '0;
		do_next_try = 1'b0;
		do_probe = 1'b0;
		blk_done = 1'b0;
		check_ok = 1'b0;
		ok = 1'b0;
		is_new = 1'b0;
		room = '0; add = '0; off = '0; retr_after = '0;
		size = long_q ? 11'd1024 : 11'd128;
		prev = exp_q - 8'd1;
		tmr_inc = (tmr_q == 16'hFFFF) ? tmr_q : tmr_q + 16'd1;
		try_p1 = try_q + 5'd1;

		unique case (kind)
			IK_START: begin
				try_n = '0; probe_n = PR_C; crcm_n = 1'b0; exp_n = 8'd1;
				retr_n = cfg.max_retrans; clen_n = '0; idx_n = '0; act_n = ACT_NONE;
				do_probe = 1'b1;
			end
			IK_BYTE: begin
				unique case (phase_q)
					PH_PROBE: begin
						if (rx_byte == B_SOH || rx_byte == B_STX) begin
							long_n = (rx_byte == B_STX);
							if (probe_q == PR_C) crcm_n = 1'b1;
							probe_n = PR_NONE; idx_n = '0; crc_n = '0; sum_n = '0;
							crch_n = '0; phase_n = PH_BLOCK; tmr_n = '0;
						end else if (rx_byte == B_EOT) begin
							act_n = ACT_END; phase_n = PH_FLUSH; tmr_n = '0;
						end else if (rx_byte == B_CAN) begin
							phase_n = PH_CANW; tmr_n = '0;
						end else do_next_try = 1'b1;
					end
					PH_CANW: begin
						if (rx_byte == B_CAN) begin
							act_n = ACT_CANCEL; phase_n = PH_FLUSH; tmr_n = '0;
						end else do_next_try = 1'b1;
					end
					PH_BLOCK: begin
						tmr_n = '0;
						idx_n = idx_q + 11'd1;
						if (idx_q == 11'd0) bnum_n = rx_byte;
						else if (idx_q == 11'd1) bcmp_n = rx_byte;
						else if (idx_q < size + 11'd2) begin
							// One extra bit keeps offsets past the 24-bit range from wrapping.
							off = {1'b0, clen_q} + 25'(idx_q - 11'd2);
							if (off < {1'b0, cfg.dest_size}) begin
								g.res[0] = mk_res(OK_DATA, rx_byte, off[23:0], '0, '0);
								g.count = 3'd1;
							end
							crc_n = crc_feed(crc_q, rx_byte);
							sum_n = sum_q + rx_byte;
						end else if (idx_q == size + 11'd2 && crcm_q) begin
							crch_n = rx_byte;
						end else begin
							blk_done = 1'b1;
							check_ok = (idx_q == size + 11'd2) ? (rx_byte == sum_q)
								: ({crch_q, rx_byte} == crc_q);
						end
					end
					PH_FLUSH: tmr_n = '0;
					default: ;
				endcase
			end
			IK_TICK: begin
				unique case (phase_q)
					PH_PROBE: begin
						tmr_n = tmr_inc;
						if (tmr_inc >= cfg.start_to) do_next_try = 1'b1;
					end
					PH_CANW: begin
						tmr_n = tmr_inc;
						if (tmr_inc >= cfg.byte_to) do_next_try = 1'b1;
					end
					PH_BLOCK: begin
						tmr_n = tmr_inc;
						if (tmr_inc >= cfg.byte_to) begin
							act_n = ACT_NAK; phase_n = PH_FLUSH; tmr_n = '0;
						end
					end
					PH_FLUSH: begin
						tmr_n = tmr_inc;
						if (tmr_inc >= cfg.flush_to) begin
							act_n = ACT_NONE;
							unique case (act_q)
								ACT_NAK: begin
									g.res[0] = mk_res(OK_TX, B_NAK, '0, '0, '0);
									g.count = 3'd1;
									try_n = '0; do_probe = 1'b1;
								end
								ACT_END, ACT_CANCEL: begin
									g.res[0] = mk_res(OK_TX, B_ACK, '0, '0, '0);
									g.res[1] = mk_res(OK_FINISH, '0, '0, clen_q,
										(act_q == ACT_END) ? ST_NORMAL : ST_CANCEL);
									g.count = 3'd2;
									phase_n = PH_IDLE;
								end
								ACT_SYNC, ACT_RETRY: begin
									g.res[0] = mk_res(OK_TX, B_CAN, '0, '0, '0);
									g.res[1] = g.res[0];
									g.res[2] = g.res[0];
									g.res[3] = mk_res(OK_FINISH, '0, '0, clen_q,
										(act_q == ACT_SYNC) ? ST_SYNC : ST_RETRY);
									g.count = 3'd4;
									phase_n = PH_IDLE;
								end
								default: begin
									try_n = '0; do_probe = 1'b1;
								end
							endcase
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		if (blk_done) begin
			ok = check_ok && (bnum_q == ~bcmp_q) && (bnum_q == exp_q || bnum_q == prev);
			is_new = (bnum_q == exp_q);
			if (!ok) begin
				act_n = ACT_NAK; phase_n = PH_FLUSH; tmr_n = '0;
			end else begin
				if (is_new) begin
					if (cfg.dest_size > clen_q) begin
						room = cfg.dest_size - clen_q;
						add = (room > 24'(size)) ? 24'(size) : room;
						clen_n = clen_q + add;
					end
					exp_n = exp_q + 8'd1;
					retr_after = cfg.max_retrans;
				end else retr_after = (retr_q != 5'd0) ? retr_q - 5'd1 : retr_q;
				retr_n = retr_after;
				if (retr_after == 5'd0) begin
					act_n = ACT_RETRY; phase_n = PH_FLUSH; tmr_n = '0;
				end else begin
					g.res[0] = mk_res(OK_TX, B_ACK, '0, '0, '0);
					g.count = 3'd1;
					try_n = '0; do_probe = 1'b1;
				end
			end
		end

		if (do_next_try) begin
			try_n = try_p1;
			if (try_p1 < TRIES) do_probe = 1'b1;
			else if (probe_q == PR_C) begin
				probe_n = PR_NAK; try_n = '0; do_probe = 1'b1;
			end else begin
				act_n = ACT_SYNC; phase_n = PH_FLUSH; tmr_n = '0;
			end
		end

		// The probe uses the probe char as it stands after this item's updates.
		if (do_probe) begin
			phase_n = PH_PROBE; tmr_n = '0;
			if (probe_n != PR_NONE) begin
				g.res[g.count[1:0]] = mk_res(OK_TX, (probe_n == PR_C) ? B_C : B_NAK,
					'0, '0, '0);
				g.count = g.count + 3'd1;
			end
		end

		if (g.count != 3'd0) g.res[2'(g.count - 3'd1)].last = 1'b1;
	end

	assign grp = g;
endmodule

### sv/xmr_outq.sv
// ----------------------------------------------------------------------------
// XMODEM receiver result queue
// Eight-entry FIFO that takes a group of up to four results per cycle.
// ----------------------------------------------------------------------------
module xmr_outq
	import xmr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  result_group_t grp,
	output logic          room4,
	xmr_out_if.source     out_ch
);
	result_t    mem_q [8];
	logic [2:0] rd_q, wr_q;
	logic [3:0] cnt_q;
	logic       pop;
	logic [2:0] n_push;

	assign pop = out_ch.valid && out_ch.ready;
	assign n_push = push ? grp.count : 3'd0;
	assign room4 = (cnt_q <= 4'd4);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++)
			if (3'(i) < n_push) mem_q[3'(wr_q + 3'(i))] <= grp.res[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			wr_q <= wr_q + n_push;
			if (pop) rd_q <= rd_q + 3'd1;
			cnt_q <= cnt_q + 4'(n_push) - 4'(pop);
		end
	end

	always_comb begin
		out_ch.valid = (cnt_q != 4'd0);
		out_ch.out_kind = mem_q[rd_q].out_kind;
		out_ch.out_byte = mem_q[rd_q].out_byte;
		out_ch.offset = mem_q[rd_q].offset;
		out_ch.total_length = mem_q[rd_q].total_length;
		out_ch.status = mem_q[rd_q].status;
		out_ch.last = mem_q[rd_q].last;
	end
endmodule

### sv/xmr_checker.sv
// ----------------------------------------------------------------------------
// XMODEM receiver port checker
// Watches the channel ports for handshake and result rules.
// ----------------------------------------------------------------------------
module xmr_checker
	import xmr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_kind,
	input logic [7:0]  out_byte,
	input logic [1:0]  status,
	input logic [23:0] offset,
	input logic        last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("stalled result changed");

	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == OK_FINISH |-> last)
		else $error("finish result not last");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_kind != 2'd3)
		else $error("bad result kind");

	a_tx_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == OK_TX |-> offset == 24'd0 && status == ST_NORMAL)
		else $error("transmit result carries stray fields");
endmodule

bind xmodem_block_receiver_unit xmr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_kind(out_ch.out_kind), .out_byte(out_ch.out_byte), .status(out_ch.status),
	.offset(out_ch.offset), .last(out_ch.last)
);

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// XMODEM block receiver testbench
// Drives start, line-byte and tick transactions through valid/ready channels.
// The expected transmit bytes, payload writes and session finishes are worked
// out by an in-bench protocol tracker and compared in order with the results.
// ----------------------------------------------------------------------------
module tb_top;
	import xmr_pkg::*;

	localparam int TRIES = 16;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] b;
	} line_item_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [23:0] cfg_data;

	xmr_in_if in_ch();
	xmr_out_if out_ch();

	xmodem_block_receiver_unit #(.TRIES_PER_ROUND(TRIES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Register mirror and tracker state.
	logic [23:0] cfg_dest;
	logic [15:0] cfg_start_to, cfg_byte_to, cfg_flush_to;
	logic [4:0]  cfg_max_retr;

	phase_t      rx_phase;
	logic [4:0]  rx_try;
	probe_t      rx_probe;
	logic        rx_crc_mode;
	logic [7:0]  rx_exp_blk;
	logic [4:0]  rx_retr_left;
	logic [23:0] rx_committed;
	logic [10:0] rx_idx;
	logic        rx_long;
	logic [7:0]  rx_blk_num, rx_blk_cpl;
	logic [15:0] rx_crc;
	logic [7:0]  rx_sum, rx_crc_hi;
	logic [15:0] rx_timer;
	act_t        rx_pending;

	result_t     step_res[4];
	int          step_n;
	result_t     expected_results[$];
	line_item_t  pending_items[$];

	int errors = 0;
	int cycles = 0;
	int sent = 0;
	int taken = 0;
	int gap_in = 0;
	int gap_out = 0;
	bit quiet = 0;
	line_item_t drv_item;

	function automatic logic [15:0] crc16_next(logic [15:0] c_in, logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
		return c;
	endfunction

	function void add_result(logic [1:0] k, logic [7:0] b, logic [23:0] off,
		logic [23:0] tot, logic [1:0] st);
		if (step_n < 4) begin
			step_res[step_n].out_kind = k;
			step_res[step_n].out_byte = b;
			step_res[step_n].offset = off;
			step_res[step_n].total_length = tot;
			step_res[step_n].status = st;
			step_res[step_n].last = 1'b0;
			step_n++;
		end
	endfunction

	function bit timer_done(logic [15:0] limit);
		int lim;
		lim = (limit == 16'd0) ? 1 : int'(limit);
		return int'(rx_timer) >= lim;
	endfunction

	function void begin_flush(act_t a);
		rx_pending = a;
		rx_phase = PH_FLUSH;
		rx_timer = '0;
	endfunction

	function void send_probe();
		rx_phase = PH_PROBE;
		rx_timer = '0;
		if (rx_probe == PR_C) add_result(OK_TX, B_C, '0, '0, ST_NORMAL);
		else if (rx_probe == PR_NAK) add_result(OK_TX, B_NAK, '0, '0, ST_NORMAL);
	endfunction

	function void retry_probe();
		rx_try = rx_try + 5'd1;
		if (rx_try < TRIES) begin
			send_probe();
		end else if (rx_probe == PR_C) begin
			rx_probe = PR_NAK;
			rx_try = '0;
			send_probe();
		end else begin
			begin_flush(ACT_SYNC);
		end
	endfunction

	function void end_session(logic [1:0] st);
		add_result(OK_FINISH, 8'h00, '0, rx_committed, st);
		rx_phase = PH_IDLE;
		rx_pending = ACT_NONE;
	endfunction

	function void run_pending();
		act_t a;
		a = rx_pending;
		rx_pending = ACT_NONE;
		case (a)
			ACT_NAK: begin
				add_result(OK_TX, B_NAK, '0, '0, ST_NORMAL);
				rx_try = '0;
				send_probe();
			end
			ACT_END: begin
				add_result(OK_TX, B_ACK, '0, '0, ST_NORMAL);
				end_session(ST_NORMAL);
			end
			ACT_CANCEL: begin
				add_result(OK_TX, B_ACK, '0, '0, ST_NORMAL);
				end_session(ST_CANCEL);
			end
			ACT_SYNC, ACT_RETRY: begin
				for (int i = 0; i < 3; i++) add_result(OK_TX, B_CAN, '0, '0, ST_NORMAL);
				end_session(a == ACT_SYNC ? ST_SYNC : ST_RETRY);
			end
			default: begin
				rx_try = '0;
				send_probe();
			end
		endcase
	endfunction

	function void close_block(bit check_ok);
		int size;
		int room;
		logic [7:0] prev;
		bit ok;
		size = rx_long ? 1024 : 128;
		prev = rx_exp_blk - 8'd1;
		ok = check_ok && (rx_blk_num == ~rx_blk_cpl) &&
			(rx_blk_num == rx_exp_blk || rx_blk_num == prev);
		if (!ok) begin
			begin_flush(ACT_NAK);
			return;
		end
		if (rx_blk_num == rx_exp_blk) begin
			if (cfg_dest > rx_committed) begin
				room = int'(cfg_dest) - int'(rx_committed);
				rx_committed = rx_committed + 24'((room > size) ? size : room);
			end
			rx_exp_blk = rx_exp_blk + 8'd1;
			rx_retr_left = cfg_max_retr;
		end else if (rx_retr_left > 5'd0) begin
			rx_retr_left = rx_retr_left - 5'd1;
		end
		if (rx_retr_left == 5'd0) begin
			begin_flush(ACT_RETRY);
			return;
		end
		add_result(OK_TX, B_ACK, '0, '0, ST_NORMAL);
		rx_try = '0;
		send_probe();
	endfunction

	function void take_block_byte(logic [7:0] b);
		int size;
		int idx;
		int off;
		size = rx_long ? 1024 : 128;
		idx = int'(rx_idx);
		rx_timer = '0;
		rx_idx = rx_idx + 11'd1;
		if (idx == 0) begin
			rx_blk_num = b;
		end else if (idx == 1) begin
			rx_blk_cpl = b;
		end else if (idx < size + 2) begin
			off = int'(rx_committed) + idx - 2;
			if (off < int'(cfg_dest)) add_result(OK_DATA, b, off[23:0], '0, ST_NORMAL);
			rx_crc = crc16_next(rx_crc, b);
			rx_sum = rx_sum + b;
		end else if (idx == size + 2) begin
			if (rx_crc_mode) rx_crc_hi = b;
			else close_block(b == rx_sum);
		end else begin
			close_block({rx_crc_hi, b} == rx_crc);
		end
	endfunction

	function void take_probe_byte(logic [7:0] b);
		if (b == B_SOH || b == B_STX) begin
			rx_long = (b == B_STX);
			if (rx_probe == PR_C) rx_crc_mode = 1'b1;
			rx_probe = PR_NONE;
			rx_idx = '0;
			rx_crc = '0;
			rx_sum = '0;
			rx_crc_hi = '0;
			rx_phase = PH_BLOCK;
			rx_timer = '0;
		end else if (b == B_EOT) begin
			begin_flush(ACT_END);
		end else if (b == B_CAN) begin
			rx_phase = PH_CANW;
			rx_timer = '0;
		end else begin
			retry_probe();
		end
	endfunction

	function void predict_line_item(logic [1:0] kind, logic [7:0] b);
		step_n = 0;
		case (in_kind_t'(kind))
			IK_START: begin
				rx_try = '0;
				rx_probe = PR_C;
				rx_crc_mode = 1'b0;
				rx_exp_blk = 8'd1;
				rx_retr_left = cfg_max_retr;
				rx_committed = '0;
				rx_idx = '0;
				rx_pending = ACT_NONE;
				send_probe();
			end
			IK_BYTE: begin
				case (rx_phase)
					PH_PROBE: take_probe_byte(b);
					PH_CANW: if (b == B_CAN) begin_flush(ACT_CANCEL); else retry_probe();
					PH_BLOCK: take_block_byte(b);
					PH_FLUSH: rx_timer = '0;
					default: ;
				endcase
			end
			IK_TICK: begin
				if (rx_phase != PH_IDLE && rx_timer != 16'hFFFF) rx_timer = rx_timer + 16'd1;
				case (rx_phase)
					PH_PROBE: if (timer_done(cfg_start_to)) retry_probe();
					PH_CANW: if (timer_done(cfg_byte_to)) retry_probe();
					PH_BLOCK: if (timer_done(cfg_byte_to)) begin_flush(ACT_NAK);
					PH_FLUSH: if (timer_done(cfg_flush_to)) run_pending();
					default: ;
				endcase
			end
			default: ;
		endcase
		if (step_n > 0) step_res[step_n - 1].last = 1'b1;
		for (int i = 0; i < step_n; i++) expected_results.push_back(step_res[i]);
	endfunction

	task report(string what);
		errors++;
		$display("MISMATCH at cycle %0d: %s", cycles, what);
	endtask

	function int draw_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Sender: holds an item until its transaction completes.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (in_ch.valid && taken != sent) begin
			// waiting for ready
		end else if (gap_in > 0) begin
			in_ch.valid <= 1'b0;
			gap_in--;
		end else if (pending_items.size() > 0) begin
			drv_item = pending_items.pop_front();
			in_ch.valid <= 1'b1;
			in_ch.kind <= drv_item.kind;
			in_ch.rx_byte <= drv_item.b;
			sent++;
			gap_in = draw_gap();
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (gap_out > 0) begin
			out_ch.ready <= 1'b0;
			gap_out--;
		end else begin
			out_ch.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) gap_out = draw_gap();
		end
	end

	// Monitor: inputs are predicted before results of the same edge are checked.
	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			cycles++;
			if (in_ch.valid && in_ch.ready) begin
				taken++;
				predict_line_item(in_ch.kind, in_ch.rx_byte);
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					report($sformatf("unexpected result kind %0d byte %h",
						out_ch.out_kind, out_ch.out_byte));
				end else begin
					e = expected_results.pop_front();
					if (out_ch.out_kind !== e.out_kind || out_ch.out_byte !== e.out_byte ||
						out_ch.offset !== e.offset || out_ch.total_length !== e.total_length ||
						out_ch.status !== e.status || out_ch.last !== e.last)
						report($sformatf(
							"got k%0d b%h o%0d t%0d s%0d l%0d exp k%0d b%h o%0d t%0d s%0d l%0d",
							out_ch.out_kind, out_ch.out_byte, out_ch.offset,
							out_ch.total_length, out_ch.status, out_ch.last,
							e.out_kind, e.out_byte, e.offset, e.total_length,
							e.status, e.last));
				end
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic add_item(logic [1:0] k, logic [7:0] b);
		line_item_t it;
		it.kind = k;
		it.b = b;
		pending_items.push_back(it);
	endtask

	task automatic add_ticks(int n);
		for (int i = 0; i < n; i++) add_item(IK_TICK, 8'($urandom_range(0, 255)));
	endtask

	function int flush_ticks();
		return (cfg_flush_to == 16'd0) ? 1 : int'(cfg_flush_to);
	endfunction

	// fault: 0 clean, 1 bad complement, 2 bad check value.
	task automatic add_block(logic [7:0] num, bit long_b, bit crc_m, int fault);
		int size;
		logic [15:0] crc;
		logic [7:0] sum;
		logic [7:0] d;
		size = long_b ? 1024 : 128;
		crc = '0;
		sum = '0;
		add_item(IK_BYTE, long_b ? B_STX : B_SOH);
		add_item(IK_BYTE, num);
		add_item(IK_BYTE, (fault == 1) ? num : ~num);
		for (int i = 0; i < size; i++) begin
			d = 8'($urandom_range(0, 255));
			add_item(IK_BYTE, d);
			crc = crc16_next(crc, d);
			sum = sum + d;
			if (cfg_byte_to > 16'd1 && $urandom_range(0, 40) == 0) add_ticks(1);
		end
		if (fault == 2) begin
			crc = crc ^ (16'h1 << $urandom_range(0, 15));
			sum = sum ^ 8'h5A;
		end
		if (crc_m) begin
			add_item(IK_BYTE, crc[15:8]);
			add_item(IK_BYTE, crc[7:0]);
		end else begin
			add_item(IK_BYTE, sum);
		end
	endtask

	// A block that stops after a few bytes and is dropped by the byte timeout.
	task automatic add_short_block();
		logic [7:0] num;
		int b_to;
		num = 8'($urandom_range(0, 3));
		b_to = (cfg_byte_to == 16'd0) ? 1 : int'(cfg_byte_to);
		add_item(IK_BYTE, ($urandom_range(0, 1) == 0) ? B_SOH : B_STX);
		add_item(IK_BYTE, num);
		add_item(IK_BYTE, ($urandom_range(0, 1) == 0) ? ~num : num);
		repeat ($urandom_range(0, 3)) add_item(IK_BYTE, 8'($urandom_range(0, 255)));
		add_ticks(b_to);
		add_ticks(flush_ticks());
	endtask

	task automatic add_session(int n_full);
		logic [7:0] blk;
		int r;
		int s_to;
		blk = 8'd1;
		add_item(IK_START, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 3) == 0) add_ticks($urandom_range(1, 3));
		repeat (n_full) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				add_block(blk, 1'b0, 1'b1, 0);
				blk = blk + 8'd1;
			end else if (r < 80) begin
				add_block(blk - 8'd1, 1'b0, 1'b1, 0);
			end else begin
				add_block(blk, 1'b0, 1'b1, (r < 90) ? 1 : 2);
				add_ticks(flush_ticks());
			end
		end
		if (n_full == 0 && cfg_byte_to <= 16'd8) add_short_block();
		s_to = (cfg_start_to == 16'd0) ? 1 : int'(cfg_start_to);
		r = $urandom_range(0, 5);
		case (r)
			0, 1: begin add_item(IK_BYTE, B_EOT); add_ticks(flush_ticks()); end
			2: begin
				add_item(IK_BYTE, B_CAN);
				add_item(IK_BYTE, B_CAN);
				add_ticks(flush_ticks());
			end
			3: begin add_item(IK_BYTE, B_CAN); add_item(IK_BYTE, 8'($urandom_range(0, 255))); end
			4: if (s_to <= 3) add_ticks(32 * s_to + flush_ticks());
			default: add_item(IK_NONE, 8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic write_reg(reg_idx_t idx, logic [23:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DEST_SIZE: cfg_dest = val;
			REG_START_TO: cfg_start_to = val[15:0];
			REG_BYTE_TO: cfg_byte_to = val[15:0];
			REG_FLUSH: cfg_flush_to = val[15:0];
			default: cfg_max_retr = val[4:0];
		endcase
	endtask

	task automatic set_regs(logic [23:0] d, logic [15:0] st, logic [15:0] bt,
		logic [15:0] ft, logic [4:0] mr);
		write_reg(REG_DEST_SIZE, d);
		write_reg(REG_START_TO, 24'(st));
		write_reg(REG_BYTE_TO, 24'(bt));
		write_reg(REG_FLUSH, 24'(ft));
		write_reg(REG_MAX_RETR, 24'(mr));
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DEST_SIZE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.kind = IK_NONE;
		in_ch.rx_byte = '0;
		out_ch.ready = 1'b0;
		cfg_dest = 24'hFFFFFF;
		cfg_start_to = 16'd2000;
		cfg_byte_to = 16'd1000;
		cfg_flush_to = 16'd1500;
		cfg_max_retr = RETRANS_RESET;
		rx_phase = PH_IDLE;
		rx_try = '0;
		rx_probe = PR_C;
		rx_crc_mode = 1'b0;
		rx_exp_blk = 8'd1;
		rx_retr_left = RETRANS_RESET;
		rx_committed = '0;
		rx_idx = '0;
		rx_long = 1'b0;
		rx_blk_num = '0;
		rx_blk_cpl = '0;
		rx_crc = '0;
		rx_sum = '0;
		rx_crc_hi = '0;
		rx_timer = '0;
		rx_pending = ACT_NONE;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: idle line, restarts, lone CAN, timeouts, remote cancel, EOT.
		set_regs(24'd200, 16'd2, 16'd2, 16'd1, 5'd1);
		add_item(IK_NONE, 8'hFF);
		add_item(IK_TICK, 8'h00);
		add_item(IK_BYTE, 8'h55);
		add_item(IK_START, 8'h00);
		add_ticks(2);
		add_item(IK_BYTE, 8'h00);
		add_item(IK_BYTE, B_CAN);
		add_item(IK_BYTE, 8'hAA);
		add_item(IK_BYTE, B_CAN);
		add_ticks(2);
		add_item(IK_START, 8'hFF);
		add_item(IK_BYTE, B_CAN);
		add_item(IK_BYTE, B_CAN);
		add_item(IK_BYTE, 8'hFF);
		add_ticks(1);
		add_item(IK_START, 8'h80);
		add_item(IK_BYTE, B_EOT);
		add_ticks(1);
		add_item(IK_BYTE, 8'h7F);
		wait_drained();

		for (int p = 1; p <= 6; p++) begin
			case (p)
				1: set_regs(24'hFFFFFF, 16'd3, 16'd4, 16'd2, 5'd31);
				2: set_regs(24'd0, 16'd1, 16'd1, 16'd1, 5'd2);
				3: set_regs(24'd300, 16'd0, 16'hFFFF, 16'd0, 5'd0);
				4: set_regs(24'd1000, 16'hFFFF, 16'd3, 16'd3, 5'd1);
				default: set_regs(24'($urandom_range(0, 2000)), 16'($urandom_range(1, 4)),
					16'($urandom_range(2, 5)), 16'($urandom_range(1, 3)),
					5'($urandom_range(0, 31)));
			endcase
			quiet = (p == 1);
			add_session((p == 1) ? 1 : 0);
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
